FILE: hw/rtl/dscr_pkg.sv
// Shared types and constants for the dual serial controller register block.
`default_nettype none
package dscr_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int REG_COUNT  = 16;

  localparam int RX_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int RX_IDX_W = $clog2(FIFO_DEPTH);
  localparam int REG_IDX_W = $clog2(REG_COUNT);

  // A mouse report needs three free slots.
  localparam logic [RX_CNT_W-1:0] MOUSE_MAX_FILL = RX_CNT_W'(FIFO_DEPTH - 3);

  typedef enum logic [2:0] {
    CMD_CTRL_RD  = 3'd0,
    CMD_CTRL_WR  = 3'd1,
    CMD_DATA_RD  = 3'd2,
    CMD_DATA_WR  = 3'd3,
    CMD_MOUSE    = 3'd4,
    CMD_INT_ACK  = 3'd5
  } cmd_e;

  // Register numbers as seen through the pointer.
  localparam logic [REG_IDX_W-1:0] WR_POINTER  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] WR_INT_MODE = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] WR_VECTOR   = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] WR_RX_CTRL  = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] WR_TX_CTRL  = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] WR_MASTER   = REG_IDX_W'(9);
  localparam logic [REG_IDX_W-1:0] RR_STATUS   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] RR_SPECIAL  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] RR_VECTOR   = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] RR_INT_PEND = REG_IDX_W'(3);

  // Fixed status bits.
  localparam logic [7:0] RR0_RX_AVAIL = 8'h01;
  localparam logic [7:0] RR0_TX_EMPTY = 8'h04;
  localparam logic [7:0] RR0_DCD      = 8'h08;
  localparam logic [7:0] RR0_CTS      = 8'h20;
  localparam logic [7:0] RR1_ALL_SENT = 8'h01;
  localparam logic [7:0] RR3_B_RX_IP  = 8'h04;
  localparam logic [7:0] RR3_A_RX_IP  = 8'h20;

  localparam logic [7:0] BTN_LEFT  = 8'h02;
  localparam logic [7:0] BTN_RIGHT = 8'h01;

  localparam logic [8:0] VEC_OFS_B = 9'd4;
  localparam logic [8:0] VEC_OFS_A = 9'd12;

  typedef struct packed {
    logic [2:0]         command;
    logic               channel;
    logic [7:0]         write_value;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic               left_pressed;
    logic               right_pressed;
  } req_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       report_accepted;
    logic [8:0] int_vector;
    logic       irq_pending;
  } rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dscr_engine.sv
// Register file, receive FIFO and interrupt logic; executes one request per fire.
`default_nettype none
module dscr_engine import dscr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic fire_i,
  input  wire req_t req_i,
  output rsp_t      rsp_o
);

  logic [7:0]           regs_q [2][REG_COUNT];
  logic [7:0]           regs_d [2][REG_COUNT];
  logic [7:0]           vector_q, vector_d;
  logic [7:0]           master_q, master_d;
  logic [REG_IDX_W-1:0] ptr_q [2];
  logic [REG_IDX_W-1:0] ptr_d [2];
  logic [7:0]           fifo_q [FIFO_DEPTH];
  logic [7:0]           fifo_d [FIFO_DEPTH];
  logic [RX_CNT_W-1:0]  cnt_q, cnt_d;
  logic [1:0]           pend_q, pend_d;

  logic                 ch;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [RX_IDX_W-1:0]  wr_idx;
  logic                 refresh_a, refresh_b;

  function automatic logic [7:0] sat_byte(input logic signed [15:0] d);
    logic [7:0] r;
    if (d < -16'sd128) begin
      r = 8'h80;
    end else if (d > 16'sd127) begin
      r = 8'h7F;
    end else begin
      r = d[7:0];
    end
    return r;
  endfunction

  // Only channel B's receiver is fed, so channel A's FIFO is always empty and
  // is not built; its pending bit can only ever be recomputed to zero.
  always_comb begin
    regs_d    = regs_q;
    vector_d  = vector_q;
    master_d  = master_q;
    ptr_d     = ptr_q;
    fifo_d    = fifo_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    rsp_o     = '0;
    refresh_a = 1'b0;
    refresh_b = 1'b0;
    ch        = req_i.channel;
    reg_idx   = ptr_q[ch];
    wr_idx    = cnt_q[RX_IDX_W-1:0];

    unique case (cmd_e'(req_i.command))
      CMD_CTRL_RD: begin
        ptr_d[ch] = '0;
        unique case (reg_idx)
          RR_STATUS: begin
            rsp_o.read_value = RR0_TX_EMPTY | RR0_DCD | RR0_CTS |
                               ((ch && cnt_q != '0) ? RR0_RX_AVAIL : 8'h00);
          end
          RR_SPECIAL: rsp_o.read_value = RR1_ALL_SENT;
          RR_VECTOR: begin
            if (ch && master_q[0] && pend_q[1]) begin
              rsp_o.read_value = vector_q + VEC_OFS_B[7:0];
            end else if (ch && master_q[0] && pend_q[0]) begin
              rsp_o.read_value = vector_q + VEC_OFS_A[7:0];
            end else begin
              rsp_o.read_value = vector_q;
            end
          end
          RR_INT_PEND: begin
            if (!ch) begin
              rsp_o.read_value = (pend_q[1] ? RR3_B_RX_IP : 8'h00) |
                                 (pend_q[0] ? RR3_A_RX_IP : 8'h00);
            end
          end
          default: rsp_o.read_value = regs_q[ch][reg_idx];
        endcase
      end
      CMD_CTRL_WR: begin
        ptr_d[ch] = '0;
        if (reg_idx == WR_POINTER) begin
          ptr_d[ch] = {req_i.write_value[3], req_i.write_value[2:0]};
          if (req_i.write_value[5:3] == 3'b111) begin
            refresh_a = !ch;
            refresh_b = ch;
          end
        end else if (reg_idx == WR_VECTOR) begin
          vector_d = req_i.write_value;
        end else if (reg_idx == WR_MASTER) begin
          master_d = req_i.write_value;
          if (!req_i.write_value[3]) begin
            pend_d = '0;
          end
        end else begin
          regs_d[ch][reg_idx] = req_i.write_value;
          if (reg_idx == WR_RX_CTRL && !req_i.write_value[0]) begin
            if (ch) begin
              cnt_d = '0;
            end
            pend_d[ch] = 1'b0;
          end
          if (reg_idx == WR_INT_MODE) begin
            refresh_a = !ch;
            refresh_b = ch;
          end
        end
      end
      CMD_DATA_RD: begin
        if (ch && cnt_q != '0) begin
          rsp_o.read_value = fifo_q[0];
          for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
            fifo_d[i] = fifo_q[i+1];
          end
          cnt_d     = cnt_q - RX_CNT_W'(1);
          refresh_b = 1'b1;
        end
      end
      CMD_DATA_WR: begin
      end
      CMD_MOUSE: begin
        if (regs_q[1][WR_RX_CTRL][0] && regs_q[1][WR_TX_CTRL][1] &&
            cnt_q <= MOUSE_MAX_FILL) begin
          fifo_d[wr_idx] = (req_i.left_pressed ? BTN_LEFT : 8'h00) |
                           (req_i.right_pressed ? BTN_RIGHT : 8'h00);
          fifo_d[RX_IDX_W'(wr_idx + RX_IDX_W'(1))] = sat_byte(req_i.delta_x);
          fifo_d[RX_IDX_W'(wr_idx + RX_IDX_W'(2))] = sat_byte(req_i.delta_y);
          cnt_d                 = cnt_q + RX_CNT_W'(3);
          refresh_b             = 1'b1;
          rsp_o.report_accepted = 1'b1;
        end
      end
      CMD_INT_ACK: begin
        if (pend_q[1]) begin
          rsp_o.int_vector = {1'b0, vector_q} + VEC_OFS_B;
          pend_d[1]        = 1'b0;
        end else if (pend_q[0]) begin
          rsp_o.int_vector = {1'b0, vector_q} + VEC_OFS_A;
          pend_d[0]        = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // Pending is re-evaluated against the state as it stands after the request.
    if (refresh_b) begin
      pend_d[1] = (cnt_d != '0) && (regs_d[1][WR_INT_MODE][4:3] != 2'b00) && master_d[3];
    end
    if (refresh_a) begin
      pend_d[0] = 1'b0;
    end

    rsp_o.irq_pending = |pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        for (int r = 0; r < REG_COUNT; r++) begin
          regs_q[c][r] <= '0;
        end
        ptr_q[c] <= '0;
      end
      vector_q <= '0;
      master_q <= '0;
      cnt_q    <= '0;
      pend_q   <= '0;
    end else if (fire_i) begin
      regs_q   <= regs_d;
      ptr_q    <= ptr_d;
      vector_q <= vector_d;
      master_q <= master_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
    end
  end

  // Entries past the fill count are never read, so the FIFO needs no reset.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      fifo_q <= fifo_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dual_serial_controller_regs_core.sv
// Top level of the dual serial controller register block with request and result registers.
`default_nettype none
// Each request (control read or write, data read or write, mouse report or
// interrupt acknowledge) is captured in an input register, executed by the
// combinational register and FIFO logic, and its result held in an output
// register, so one request is taken every cycle while the result side keeps
// up; a stall on the result side holds a request in the input register. Mouse reports
// always go to channel B's receive FIFO; channel A's receiver never holds data.
module dual_serial_controller_regs_core import dscr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        command_i,
  input  wire logic              channel_i,
  input  wire logic [7:0]        write_value_i,
  input  wire logic signed [15:0] delta_x_i,
  input  wire logic signed [15:0] delta_y_i,
  input  wire logic              left_pressed_i,
  input  wire logic              right_pressed_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [7:0]             read_value_o,
  output logic                   report_accepted_o,
  output logic [8:0]             int_vector_o,
  output logic                   irq_pending_o
);

  logic s1_valid_q;
  req_t s1_req_q;
  logic out_valid_q;
  rsp_t rsp_q;
  rsp_t rsp_d;
  logic out_free;
  logic fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  dscr_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (s1_req_q),
    .rsp_o  (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_req_q.command       <= command_i;
      s1_req_q.channel       <= channel_i;
      s1_req_q.write_value   <= write_value_i;
      s1_req_q.delta_x       <= delta_x_i;
      s1_req_q.delta_y       <= delta_y_i;
      s1_req_q.left_pressed  <= left_pressed_i;
      s1_req_q.right_pressed <= right_pressed_i;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_value_o      = rsp_q.read_value;
  assign report_accepted_o = rsp_q.report_accepted;
  assign int_vector_o      = rsp_q.int_vector;
  assign irq_pending_o     = rsp_q.irq_pending;

endmodule
`default_nettype wire

FILE: tb/sv/dscr_checker.sv
// Checker for the dual serial controller register block: predicts each result and compares it.
module dscr_checker import dscr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [2:0]         command_i,
  input  wire logic               channel_i,
  input  wire logic [7:0]         write_value_i,
  input  wire logic signed [15:0] delta_x_i,
  input  wire logic signed [15:0] delta_y_i,
  input  wire logic               left_pressed_i,
  input  wire logic               right_pressed_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic [7:0]         read_value_i,
  input  wire logic               report_accepted_i,
  input  wire logic [8:0]         int_vector_i,
  input  wire logic               irq_pending_i,
  output int                      fail_count_o,
  output int                      backlog_o
);

  localparam int CH_A = 0;
  localparam int CH_B = 1;

  localparam logic [7:0] MASTER_VIS    = 8'h01;
  localparam logic [7:0] MASTER_IRQ_EN = 8'h08;
  localparam logic [7:0] INT_MODE_MASK = 8'h18;
  localparam logic [7:0] PTR_CMD_MASK  = 8'h38;
  localparam logic [7:0] RX_ENABLE     = 8'h01;
  localparam logic [7:0] TX_RTS        = 8'h02;

  logic [7:0] wr_regs [2][REG_COUNT];
  logic [7:0] vector_reg;
  logic [7:0] master_reg;
  logic [3:0] reg_ptr [2];
  logic [7:0] rx_bytes [2][FIFO_DEPTH];
  int         rx_fill [2];
  logic       rx_irq [2];

  rsp_t predicted_q [$];
  int   mismatches = 0;
  int   backlog = 0;

  assign fail_count_o = mismatches;
  assign backlog_o    = backlog;

  function automatic void reset_model();
    int c;
    int k;
    for (c = 0; c < 2; c++) begin
      for (k = 0; k < REG_COUNT; k++) wr_regs[c][k] = 8'h00;
      for (k = 0; k < FIFO_DEPTH; k++) rx_bytes[c][k] = 8'h00;
      reg_ptr[c] = 4'h0;
      rx_fill[c] = 0;
      rx_irq[c]  = 1'b0;
    end
    vector_reg = 8'h00;
    master_reg = 8'h00;
  endfunction

  function automatic void update_irq(input int ch);
    rx_irq[ch] = rx_fill[ch] > 0 && (wr_regs[ch][WR_INT_MODE] & INT_MODE_MASK) != 0 &&
                 (master_reg & MASTER_IRQ_EN) != 0;
  endfunction

  function automatic logic [7:0] clamp_delta(input logic signed [15:0] d);
    if (d < -16'sd128) return 8'h80;
    if (d > 16'sd127) return 8'h7F;
    return d[7:0];
  endfunction

  function automatic rsp_t serial_regs_step(input req_t rq);
    rsp_t       r;
    logic [3:0] idx;
    int         ch;
    int         n;
    int         i;
    r  = '0;
    ch = int'(rq.channel);
    case (rq.command)
      CMD_CTRL_RD: begin
        idx = reg_ptr[ch];
        reg_ptr[ch] = 4'h0;
        case (idx)
          RR_STATUS: r.read_value = RR0_TX_EMPTY | RR0_DCD | RR0_CTS |
                                    (rx_fill[ch] > 0 ? RR0_RX_AVAIL : 8'h00);
          RR_SPECIAL: r.read_value = RR1_ALL_SENT;
          RR_VECTOR: begin
            r.read_value = vector_reg;
            // Status in vector only shows through channel B.
            if (ch == CH_B && (master_reg & MASTER_VIS) != 0) begin
              if (rx_irq[CH_B]) r.read_value = vector_reg + VEC_OFS_B[7:0];
              else if (rx_irq[CH_A]) r.read_value = vector_reg + VEC_OFS_A[7:0];
            end
          end
          RR_INT_PEND: begin
            if (ch == CH_A)
              r.read_value = (rx_irq[CH_B] ? RR3_B_RX_IP : 8'h00) |
                             (rx_irq[CH_A] ? RR3_A_RX_IP : 8'h00);
          end
          default: r.read_value = wr_regs[ch][idx];
        endcase
      end
      CMD_CTRL_WR: begin
        idx = reg_ptr[ch];
        reg_ptr[ch] = 4'h0;
        if (idx == WR_POINTER) begin
          reg_ptr[ch] = rq.write_value[3:0];
          if ((rq.write_value & PTR_CMD_MASK) == PTR_CMD_MASK) update_irq(ch);
        end else begin
          if (idx == WR_VECTOR) begin
            vector_reg = rq.write_value;
          end else if (idx == WR_MASTER) begin
            master_reg = rq.write_value;
            if ((rq.write_value & MASTER_IRQ_EN) == 0) begin
              rx_irq[CH_A] = 1'b0;
              rx_irq[CH_B] = 1'b0;
            end
          end else begin
            wr_regs[ch][idx] = rq.write_value;
          end
          if (idx == WR_RX_CTRL && (rq.write_value & RX_ENABLE) == 0) begin
            rx_fill[ch] = 0;
            rx_irq[ch]  = 1'b0;
          end
          if (idx == WR_INT_MODE) update_irq(ch);
        end
      end
      CMD_DATA_RD: begin
        if (rx_fill[ch] > 0) begin
          r.read_value = rx_bytes[ch][0];
          for (i = 1; i < rx_fill[ch]; i++) rx_bytes[ch][i-1] = rx_bytes[ch][i];
          rx_fill[ch]--;
          update_irq(ch);
        end
      end
      CMD_MOUSE: begin
        // Reports always land in channel B, whatever the channel field says.
        n = rx_fill[CH_B];
        if ((wr_regs[CH_B][WR_RX_CTRL] & RX_ENABLE) != 0 &&
            (wr_regs[CH_B][WR_TX_CTRL] & TX_RTS) != 0 && n <= FIFO_DEPTH - 3) begin
          rx_bytes[CH_B][n]   = (rq.left_pressed ? BTN_LEFT : 8'h00) |
                                (rq.right_pressed ? BTN_RIGHT : 8'h00);
          rx_bytes[CH_B][n+1] = clamp_delta(rq.delta_x);
          rx_bytes[CH_B][n+2] = clamp_delta(rq.delta_y);
          rx_fill[CH_B] = n + 3;
          update_irq(CH_B);
          r.report_accepted = 1'b1;
        end
      end
      CMD_INT_ACK: begin
        if (rx_irq[CH_B]) begin
          rx_irq[CH_B] = 1'b0;
          r.int_vector = {1'b0, vector_reg} + VEC_OFS_B;
        end else if (rx_irq[CH_A]) begin
          rx_irq[CH_A] = 1'b0;
          r.int_vector = {1'b0, vector_reg} + VEC_OFS_A;
        end
      end
      default: ;
    endcase
    r.irq_pending = rx_irq[CH_A] | rx_irq[CH_B];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [8:0] want,
                                      input logic [8:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rsp_t want;
    req_t rq;
    if (!rst_ni) begin
      reset_model();
      predicted_q.delete();
      backlog = 0;
    end else begin
      // Pop before push: a result never belongs to the request taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (predicted_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, got rd=0x%0h acc=%0d vec=0x%0h irq=%0d",
                   $time, read_value_i, report_accepted_i, int_vector_i, irq_pending_i);
        end else begin
          want = predicted_q.pop_front();
          check_field("read_value", 9'(want.read_value), 9'(read_value_i));
          check_field("report_accepted", 9'(want.report_accepted), 9'(report_accepted_i));
          check_field("int_vector", want.int_vector, int_vector_i);
          check_field("irq_pending", 9'(want.irq_pending), 9'(irq_pending_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        rq = '{command: command_i, channel: channel_i, write_value: write_value_i,
               delta_x: delta_x_i, delta_y: delta_y_i, left_pressed: left_pressed_i,
               right_pressed: right_pressed_i};
        predicted_q.push_back(serial_regs_step(rq));
      end
      backlog = predicted_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_dual_serial_controller_regs_core.sv
// Testbench top for the dual serial controller register block: stimulus, handshake pacing, verdict.
module tb_dual_serial_controller_regs_core;
  import dscr_pkg::*;

  localparam logic CH_A = 1'b0;
  localparam logic CH_B = 1'b1;

  localparam logic [2:0] CMD_UNUSED = 3'd7;

  localparam logic [7:0] MASTER_VIS    = 8'h01;
  localparam logic [7:0] MASTER_IRQ_EN = 8'h08;
  localparam logic [7:0] INT_MODE_ON   = 8'h10;
  localparam logic [7:0] RX_ENABLE     = 8'h01;
  localparam logic [7:0] TX_RTS        = 8'h02;

  localparam int    RANDOM_ITEMS = 1525;
  localparam int    DRAIN_LIMIT  = 5000;
  localparam longint RUN_LIMIT   = 10_000_000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         command;
  logic               channel;
  logic [7:0]         write_value;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic               left_pressed;
  logic               right_pressed;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         read_value;
  logic               report_accepted;
  logic [8:0]         int_vector;
  logic               irq_pending;

  int idle_pct = 0;
  int stall_pct = 0;
  int counted = 0;
  int fail_count;
  int backlog;

  dual_serial_controller_regs_core i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .command_i         (command),
    .channel_i         (channel),
    .write_value_i     (write_value),
    .delta_x_i         (delta_x),
    .delta_y_i         (delta_y),
    .left_pressed_i    (left_pressed),
    .right_pressed_i   (right_pressed),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .read_value_o      (read_value),
    .report_accepted_o (report_accepted),
    .int_vector_o      (int_vector),
    .irq_pending_o     (irq_pending)
  );

  dscr_checker i_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .command_i         (command),
    .channel_i         (channel),
    .write_value_i     (write_value),
    .delta_x_i         (delta_x),
    .delta_y_i         (delta_y),
    .left_pressed_i    (left_pressed),
    .right_pressed_i   (right_pressed),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .read_value_i      (read_value),
    .report_accepted_i (report_accepted),
    .int_vector_i      (int_vector),
    .irq_pending_i     (irq_pending),
    .fail_count_o      (fail_count),
    .backlog_o         (backlog)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) out_stall = ($urandom_range(99) < stall_pct);

  // Presents one request and holds it until the block takes it.
  task automatic send(input logic [2:0] cmd, input logic ch, input logic [7:0] wv,
                      input logic signed [15:0] dx, input logic signed [15:0] dy,
                      input logic lb, input logic rb);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    command       = cmd;
    channel       = ch;
    write_value   = wv;
    delta_x       = dx;
    delta_y       = dy;
    left_pressed  = lb;
    right_pressed = rb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!(cmd == CMD_DATA_WR || cmd > CMD_INT_ACK)) counted++;
  endtask

  task automatic plain(input logic [2:0] cmd, input logic ch, input logic [7:0] wv);
    send(cmd, ch, wv, 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Selects a register through register zero; the upper nibble sometimes carries a command.
  task automatic select_reg(input logic ch, input logic [3:0] idx);
    plain(CMD_CTRL_WR, ch, {($urandom_range(1) != 0) ? 4'($urandom) : 4'h0, idx});
  endtask

  task automatic set_reg(input logic ch, input logic [3:0] idx, input logic [7:0] val);
    select_reg(ch, idx);
    plain(CMD_CTRL_WR, ch, val);
  endtask

  task automatic get_reg(input logic ch, input logic [3:0] idx);
    select_reg(ch, idx);
    plain(CMD_CTRL_RD, ch, 8'($urandom));
  endtask

  function automatic logic signed [15:0] pick_delta();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(400)) - 16'd200;
      2: return 16'($urandom_range(255)) - 16'd128;
      default: begin
        case ($urandom_range(5))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return -16'sd129;
          3: return 16'sd128;
          4: return -16'sd128;
          default: return 16'sd127;
        endcase
      end
    endcase
  endfunction

  task automatic random_request();
    int         pick;
    logic       ch;
    logic [3:0] idx;
    logic [7:0] val;
    pick = $urandom_range(99);
    ch   = ($urandom_range(99) < 80) ? CH_B : CH_A;
    if ($urandom_range(1) != 0) begin
      idx = 4'($urandom);
    end else begin
      case ($urandom_range(4))
        0: idx = WR_INT_MODE;
        1: idx = WR_VECTOR;
        2: idx = WR_RX_CTRL;
        3: idx = WR_TX_CTRL;
        default: idx = WR_MASTER;
      endcase
    end
    if (pick < 28) begin
      val = 8'($urandom);
      // Mostly keep the receive path enabled so reports get through.
      if ($urandom_range(99) < 80) begin
        case (idx)
          WR_INT_MODE: val |= INT_MODE_ON;
          WR_RX_CTRL:  val |= RX_ENABLE;
          WR_TX_CTRL:  val |= TX_RTS;
          WR_MASTER:   val |= MASTER_IRQ_EN;
          default: ;
        endcase
      end
      set_reg(ch, idx, val);
    end else if (pick < 40) begin
      get_reg(ch, idx);
    end else if (pick < 58) begin
      send(CMD_MOUSE, 1'($urandom), 8'($urandom), pick_delta(), pick_delta(),
           1'($urandom), 1'($urandom));
    end else if (pick < 85) begin
      plain(CMD_DATA_RD, ch, 8'($urandom));
    end else if (pick < 92) begin
      plain(CMD_INT_ACK, ch, 8'($urandom));
    end else if (pick < 96) begin
      plain(CMD_CTRL_RD, ch, 8'($urandom));
    end else begin
      send(3'($urandom), 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
           1'($urandom), 1'($urandom));
    end
  endtask

  initial begin : stimulus
    int target;
    int ph;
    int waited;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    out_stall     = 1'b0;
    command       = CMD_CTRL_RD;
    channel       = CH_A;
    write_value   = 8'h00;
    delta_x       = 16'sd0;
    delta_y       = 16'sd0;
    left_pressed  = 1'b0;
    right_pressed = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    plain(CMD_CTRL_RD, CH_A, 8'h00);
    plain(CMD_DATA_RD, CH_B, 8'h00);
    plain(CMD_INT_ACK, CH_A, 8'h00);
    // Receiver still off, so this report is refused.
    send(CMD_MOUSE, CH_A, 8'h00, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1);
    send(CMD_UNUSED, CH_B, 8'hFF, 16'shFFFF, 16'shFFFF, 1'b1, 1'b1);
    plain(CMD_DATA_WR, CH_A, 8'hFF);
    set_reg(CH_B, WR_RX_CTRL, RX_ENABLE);
    set_reg(CH_B, WR_TX_CTRL, TX_RTS);
    set_reg(CH_B, WR_INT_MODE, INT_MODE_ON);
    set_reg(CH_A, WR_MASTER, MASTER_IRQ_EN | MASTER_VIS);
    set_reg(CH_A, WR_VECTOR, 8'hFF);
    send(CMD_MOUSE, CH_A, 8'h00, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1);
    send(CMD_MOUSE, CH_B, 8'h00, 16'sd127, -16'sd128, 1'b0, 1'b0);
    // Only two slots left in the FIFO: refused.
    send(CMD_MOUSE, CH_B, 8'h00, 16'sd128, -16'sd129, 1'b1, 1'b0);
    // Vector with status wraps past 8 bits.
    get_reg(CH_B, RR_VECTOR);
    get_reg(CH_A, RR_INT_PEND);
    plain(CMD_INT_ACK, CH_B, 8'h00);
    plain(CMD_DATA_RD, CH_B, 8'h00);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      target = counted + RANDOM_ITEMS / 4;
      while (counted < target) random_request();
    end

    @(negedge clk);
    in_valid = 1'b0;
    waited = 0;
    while (backlog != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (backlog == 0 && fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/dscr_pkg.sv
hw/rtl/dscr_engine.sv
hw/rtl/dual_serial_controller_regs_core.sv
tb/sv/dscr_checker.sv
tb/sv/tb_dual_serial_controller_regs_core.sv
